// ===== hdl/mrbf_pkg.sv =====
// Shared types and codes for the multi-reader broadcast FIFO.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package mrbf_pkg;

   localparam int OP_W   = 2;
   localparam int STAT_W = 2;
   localparam int ID_W   = 16;
   localparam int DATA_W = 64;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_POP    = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic        [ID_W-1:0]   id;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] stamp;
   } rec_type;

endpackage

`default_nettype wire

// ===== hdl/mrbf_store.sv =====
// Record and read-mask memories of the broadcast FIFO, one write and one
// registered read port each. Depends on mrbf_pkg.
`default_nettype none

module mrbf_store #(
   parameter int DEPTH   = 16,
   parameter int READERS = 2,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire                   clock,
   input  wire                   rec_we,
   input  wire  [ADDR_W-1:0]     rec_waddr,
   input  mrbf_pkg::rec_type     rec_wdata,
   input  wire                   mask_we,
   input  wire  [ADDR_W-1:0]     mask_waddr,
   input  wire  [READERS-1:0]    mask_wdata,
   input  wire                   rd_en,
   input  wire  [ADDR_W-1:0]     rd_addr,
   output mrbf_pkg::rec_type     rec_rdata,
   output logic [READERS-1:0]    mask_rdata
);
   import mrbf_pkg::*;

   rec_type            rec_mem  [DEPTH];
   logic [READERS-1:0] mask_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[rec_waddr] <= rec_wdata;
      end
      if (rd_en) begin
         rec_rdata <= rec_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mask_we) begin
         mask_mem[mask_waddr] <= mask_wdata;
      end
      if (rd_en) begin
         mask_rdata <= mask_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/multi_reader_broadcast_fifo.sv =====
// Top level of the multi-reader broadcast FIFO: pointer control, result register.
// Depends on mrbf_pkg and mrbf_store.
//
// Usage: each request transaction carries an operation (insert, pop for one
// reader, clear) and the record fields for an insert. Every request produces
// exactly one response transaction with a status, the popped record (zero
// unless a pop succeeded), an entry-freed flag and the occupancy after the
// operation. Each reader sees every inserted record once, in order; an entry
// is freed when its last reader pops it.
// Response timing: inserts, clears, refused inserts and empty pops are
// registered at the accepting edge and show on the response side in the next
// cycle, so they run at one per cycle while the response is not stalled. A
// successful pop passes through S_POP: the memories have a registered read and
// the mask is written back in S_POP, while req_stall holds off new requests.
// When the receiver stalls the response, the result stays in the output
// register and req_stall stays high for as long as that result waits there.
// Reset (synchronous, active high) empties the ring and rewinds every reader;
// the memories are not cleared and need no clearing pass.
`default_nettype none

module multi_reader_broadcast_fifo #(
   parameter int DEPTH   = 16,
   parameter int READERS = 2,
   localparam int ADDR_W = $clog2(DEPTH),
   localparam int CNT_W  = $clog2(DEPTH + 1),
   localparam int RD_W   = (READERS > 1) ? $clog2(READERS) : 1
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  [mrbf_pkg::OP_W-1:0]    req_operation,
   input  wire  [RD_W-1:0]              req_reader,
   input  wire  [mrbf_pkg::ID_W-1:0]    req_sample_id,
   input  wire  signed [mrbf_pkg::DATA_W-1:0] req_sample_value,
   input  wire  signed [mrbf_pkg::DATA_W-1:0] req_sample_time,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [mrbf_pkg::STAT_W-1:0]  rsp_status,
   output logic [mrbf_pkg::ID_W-1:0]    rsp_out_id,
   output logic signed [mrbf_pkg::DATA_W-1:0] rsp_out_value,
   output logic signed [mrbf_pkg::DATA_W-1:0] rsp_out_time,
   output logic                         rsp_entry_freed,
   output logic [CNT_W-1:0]             rsp_occupancy
);
   import mrbf_pkg::*;

   localparam logic [0:0] S_IDLE = 1'b0;
   localparam logic [0:0] S_POP  = 1'b1;

   logic [0:0]        state_ff, state_in;
   logic [ADDR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] rdptr_ff  [READERS];
   logic [ADDR_W-1:0] rdptr_in  [READERS];
   logic [CNT_W-1:0]  unread_ff [READERS];
   logic [CNT_W-1:0]  unread_in [READERS];
   logic [ADDR_W-1:0] pop_addr_ff, pop_addr_in;
   logic [RD_W-1:0]   pop_rd_ff, pop_rd_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   rec_type           rsp_rec_ff, rsp_rec_in;
   logic              rsp_freed_ff, rsp_freed_in;
   logic [CNT_W-1:0]  rsp_occ_ff, rsp_occ_in;

   logic               accept;
   logic               out_free;
   logic               rd_ok;
   logic               pop_go;
   logic [ADDR_W-1:0]  rd_addr;
   logic               rec_we;
   rec_type            rec_wdata;
   logic               mask_we;
   logic [ADDR_W-1:0]  mask_waddr;
   logic [READERS-1:0] mask_wdata;
   rec_type            rec_rdata;
   logic [READERS-1:0] mask_rdata;
   logic [READERS-1:0] rd_sel;
   logic [READERS-1:0] new_mask;
   logic               freed;

   function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] idx);
      return (idx == ADDR_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;

   assign rd_ok   = ({1'b0, req_reader} < (RD_W + 1)'(READERS));
   assign rd_addr = rd_ok ? rdptr_ff[req_reader] : '0;
   assign pop_go  = accept && (req_operation == OP_POP) && rd_ok
                    && (unread_ff[req_reader] != '0);

   always_comb begin
      for (int r = 0; r < READERS; r++) begin
         rd_sel[r] = (pop_rd_ff == RD_W'(r));
      end
   end

   assign new_mask = mask_rdata | rd_sel;
   assign freed    = &new_mask;

   assign rec_wdata.id    = req_sample_id;
   assign rec_wdata.value = req_sample_value;
   assign rec_wdata.stamp = req_sample_time;

   always_comb begin
      state_in      = state_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      rdptr_in      = rdptr_ff;
      unread_in     = unread_ff;
      pop_addr_in   = pop_addr_ff;
      pop_rd_in     = pop_rd_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_freed_in  = rsp_freed_ff;
      rsp_occ_in    = rsp_occ_ff;
      rec_we        = 1'b0;
      mask_we       = 1'b0;
      mask_waddr    = tail_ff;
      mask_wdata    = '0;

      if (state_ff == S_POP) begin
         mask_we       = 1'b1;
         mask_waddr    = pop_addr_ff;
         mask_wdata    = new_mask;
         if (freed && (count_ff != '0)) begin
            count_in = count_ff - 1'b1;
         end
         state_in      = S_IDLE;
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_OK;
         rsp_rec_in    = rec_rdata;
         rsp_freed_in  = freed;
         rsp_occ_in    = count_in;
      end else if (accept) begin
         rsp_rec_in    = '0;
         rsp_freed_in  = 1'b0;
         rsp_status_in = ST_OK;
         rsp_valid_in  = 1'b1;
         case (req_operation)
            OP_INSERT: begin
               if (count_ff == CNT_W'(DEPTH)) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  rec_we   = 1'b1;
                  mask_we  = 1'b1;
                  tail_in  = ring_next(tail_ff);
                  count_in = count_ff + 1'b1;
                  for (int r = 0; r < READERS; r++) begin
                     unread_in[r] = unread_ff[r] + 1'b1;
                  end
               end
            end
            OP_POP: begin
               if (pop_go) begin
                  rsp_valid_in = 1'b0;
                  state_in     = S_POP;
                  pop_addr_in  = rd_addr;
                  pop_rd_in    = req_reader;
                  rdptr_in[req_reader]  = ring_next(rd_addr);
                  unread_in[req_reader] = unread_ff[req_reader] - 1'b1;
               end else begin
                  rsp_status_in = ST_EMPTY;
               end
            end
            OP_CLEAR: begin
               tail_in  = '0;
               count_in = '0;
               for (int r = 0; r < READERS; r++) begin
                  rdptr_in[r]  = '0;
                  unread_in[r] = '0;
               end
            end
            default: begin
            end
         endcase
         rsp_occ_in = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < READERS; r++) begin
            rdptr_ff[r]  <= '0;
            unread_ff[r] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rdptr_ff     <= rdptr_in;
         unread_ff    <= unread_in;
      end
   end

   always_ff @(posedge clock) begin
      pop_addr_ff   <= pop_addr_in;
      pop_rd_ff     <= pop_rd_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_freed_ff  <= rsp_freed_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   mrbf_store #(
      .DEPTH   (DEPTH),
      .READERS (READERS)
   ) u_store (
      .clock      (clock),
      .rec_we     (rec_we),
      .rec_waddr  (tail_ff),
      .rec_wdata  (rec_wdata),
      .mask_we    (mask_we),
      .mask_waddr (mask_waddr),
      .mask_wdata (mask_wdata),
      .rd_en      (pop_go),
      .rd_addr    (rd_addr),
      .rec_rdata  (rec_rdata),
      .mask_rdata (mask_rdata)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_id      = rsp_rec_ff.id;
   assign rsp_out_value   = rsp_rec_ff.value;
   assign rsp_out_time    = rsp_rec_ff.stamp;
   assign rsp_entry_freed = rsp_freed_ff;
   assign rsp_occupancy   = rsp_occ_ff;

endmodule

`default_nettype wire

// ===== hdl/mrbf_checker.sv =====
// Port-level assertions for the multi-reader broadcast FIFO, bound to the top.
// Depends on mrbf_pkg and multi_reader_broadcast_fifo.
`default_nettype none

module mrbf_checker #(
   parameter int DEPTH   = 16,
   parameter int READERS = 2,
   localparam int CNT_W  = $clog2(DEPTH + 1)
) (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_stall,
   input wire [mrbf_pkg::OP_W-1:0]     req_operation,
   input wire                          rsp_valid,
   input wire                          rsp_stall,
   input wire [mrbf_pkg::STAT_W-1:0]   rsp_status,
   input wire [mrbf_pkg::ID_W-1:0]     rsp_out_id,
   input wire                          rsp_entry_freed,
   input wire [CNT_W-1:0]              rsp_occupancy
);
   import mrbf_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_occupancy) && $stable(rsp_out_id))
      else $error("Stalled response transaction changed.");

   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_operation == OP_CLEAR)
      |=> rsp_valid && (rsp_status == ST_OK) && (rsp_occupancy == '0))
      else $error("Clear did not answer with an empty queue.");

   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> !rsp_entry_freed && (rsp_out_id == '0))
      else $error("Failed transaction carried record data.");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> (rsp_occupancy == CNT_W'(DEPTH)))
      else $error("Full status with a ring that is not full.");

endmodule

bind multi_reader_broadcast_fifo mrbf_checker #(
   .DEPTH   (DEPTH),
   .READERS (READERS)
) u_mrbf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_operation   (req_operation),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_out_id      (rsp_out_id),
   .rsp_entry_freed (rsp_entry_freed),
   .rsp_occupancy   (rsp_occupancy)
);

`default_nettype wire
